/* hw/rtl/lbs_pkg.sv */
`default_nettype none

package lbs_pkg;

  // link stages
  typedef enum logic [2:0] {
    ST_OFF  = 3'd0,
    ST_JOIN = 3'd1,
    ST_ADDR = 3'd2,
    ST_TIME = 3'd3,
    ST_CONN = 3'd4,
    ST_LINK = 3'd5,
    ST_BACK = 3'd6,
    ST_SUSP = 3'd7
  } state_t;

  // event codes
  localparam logic [3:0] OP_POLL       = 4'd0;
  localparam logic [3:0] OP_INIT       = 4'd1;
  localparam logic [3:0] OP_SET_PROV   = 4'd2;
  localparam logic [3:0] OP_JOIN       = 4'd3;
  localparam logic [3:0] OP_ADDR       = 4'd4;
  localparam logic [3:0] OP_TIME       = 4'd5;
  localparam logic [3:0] OP_TLS        = 4'd6;
  localparam logic [3:0] OP_AP_LOST    = 4'd7;
  localparam logic [3:0] OP_SRV_CLOSED = 4'd8;
  localparam logic [3:0] OP_HOST_FRAME = 4'd9;
  localparam logic [3:0] OP_HOST_DISC  = 4'd10;

  // start commands
  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_JOIN = 3'd1;
  localparam logic [2:0] CMD_ADDR = 3'd2;
  localparam logic [2:0] CMD_TIME = 3'd3;
  localparam logic [2:0] CMD_TLS  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_BACKOFF_MIN = 2'd0;
  localparam logic [1:0] REG_BACKOFF_MAX = 2'd1;
  localparam logic [1:0] REG_USB_SILENCE = 2'd2;
  localparam logic [1:0] REG_BUILD_EPOCH = 2'd3;

  localparam logic [31:0] BACKOFF_MIN_RST = 32'd1000;
  localparam logic [31:0] BACKOFF_MAX_RST = 32'd60000;
  localparam logic [31:0] USB_SILENCE_RST = 32'd5000;
  localparam logic [63:0] BUILD_EPOCH_RST = 64'd0;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [31:0] now_ms;
    logic        event_flag;
    logic        time_valid_in;
    logic [63:0] wall_epoch;
    logic [7:0]  rand_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] backoff_min_ms;
    logic [31:0] backoff_max_ms;
    logic [31:0] usb_silence_ms;
    logic [63:0] build_epoch;
  } cfg_t;

  typedef struct packed {
    state_t      link_state;
    logic        close_issued;
    logic [2:0]  start_cmd;
    logic [31:0] backoff_ms;
  } res_t;

  typedef struct packed {
    logic [31:0] interval;
    logic [31:0] deadline;
    logic [31:0] base_nxt;
  } bo_t;

  // stages that wait for a start command
  function automatic logic is_action(state_t s);
    return (s == ST_JOIN) || (s == ST_ADDR) || (s == ST_TIME) || (s == ST_CONN);
  endfunction

  // wrap-safe "t has been reached"
  function automatic logic time_due(logic [31:0] now, logic [31:0] t);
    logic [31:0] d;
    d = now - t;
    return !d[31];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lbs_if.sv */
`default_nettype none

interface lbs_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [31:0] now_ms;
  logic        event_flag;
  logic        time_valid_in;
  logic [63:0] wall_epoch;
  logic [7:0]  rand_byte;

  modport source (
    output valid, opcode, now_ms, event_flag, time_valid_in, wall_epoch, rand_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, now_ms, event_flag, time_valid_in, wall_epoch, rand_byte,
    output ready
  );
endinterface

interface lbs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  link_state;
  logic        close_issued;
  logic [2:0]  start_cmd;
  logic [31:0] backoff_ms;

  modport source (
    output valid, link_state, close_issued, start_cmd, backoff_ms,
    input  ready
  );
  modport sink (
    input  valid, link_state, close_issued, start_cmd, backoff_ms,
    output ready
  );
endinterface

interface lbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lbs_backoff.sv */
`default_nettype none

module lbs_backoff (
  input  wire logic [31:0] base,
  input  wire logic [31:0] max_ms,
  input  wire logic [7:0]  rand_byte,
  input  wire logic [31:0] now_ms,
  output lbs_pkg::bo_t     bo
);

  logic [29:0] quarter;
  logic [37:0] prod;
  logic [38:0] prod_p1;
  logic [71:0] recip;
  logic [29:0] jitter;
  logic [32:0] iv;
  logic [31:0] iv_cap;
  logic [32:0] dbl;

  assign quarter = base[31:2];
  assign prod    = 38'(rand_byte) * 38'(quarter);
  assign prod_p1 = {1'b0, prod} + 39'd1;

  // floor(prod / 255) = ((prod + 1) * (2^40 - 1) / 255) >> 40, exact below 2^40
  assign recip = (72'(prod_p1) << 32) + (72'(prod_p1) << 24) + (72'(prod_p1) << 16)
               + (72'(prod_p1) << 8) + 72'(prod_p1);
  assign jitter = recip[69:40];

  always_comb begin
    if (base == max_ms) begin
      iv = {1'b0, base} - 33'(jitter);
    end else begin
      iv = {1'b0, base} + 33'(jitter);
    end
    if (iv > {1'b0, max_ms}) begin
      iv_cap = max_ms;
    end else begin
      iv_cap = iv[31:0];
    end
    dbl = {base, 1'b0};
    bo.interval = iv_cap;
    bo.deadline = now_ms + iv_cap;
    if (base < max_ms) begin
      bo.base_nxt = (dbl > {1'b0, max_ms}) ? max_ms : dbl[31:0];
    end else begin
      bo.base_nxt = base;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lbs_seq.sv */
`default_nettype none

module lbs_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire lbs_pkg::item_t item,
  input  wire lbs_pkg::cfg_t  cfg,
  output lbs_pkg::res_t       res
);

  lbs_pkg::state_t cur_r, cur_nxt;
  lbs_pkg::state_t retry_r, retry_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] deadline_r, deadline_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] last_bo_r, last_bo_nxt;
  logic        clkv_r, clkv_nxt;
  logic        prov_r, prov_nxt;
  logic        host_r, host_nxt;
  logic [31:0] last_host_r, last_host_nxt;

  logic            close;
  logic [2:0]      cmd;
  logic            retry_go;
  lbs_pkg::state_t retry_tgt;
  lbs_pkg::bo_t    bo;

  lbs_backoff u_backoff (
    .base      (base_r),
    .max_ms    (cfg.backoff_max_ms),
    .rand_byte (item.rand_byte),
    .now_ms    (item.now_ms),
    .bo        (bo)
  );

  always_comb begin
    cur_nxt       = cur_r;
    retry_nxt     = retry_r;
    pend_nxt      = pend_r;
    deadline_nxt  = deadline_r;
    base_nxt      = base_r;
    last_bo_nxt   = last_bo_r;
    clkv_nxt      = clkv_r;
    prov_nxt      = prov_r;
    host_nxt      = host_r;
    last_host_nxt = last_host_r;
    close         = 1'b0;
    cmd           = lbs_pkg::CMD_NONE;
    retry_go      = 1'b0;
    retry_tgt     = lbs_pkg::ST_OFF;

    case (item.opcode)
      lbs_pkg::OP_POLL: begin
        if (cur_r == lbs_pkg::ST_BACK && lbs_pkg::time_due(item.now_ms, deadline_r)) begin
          cur_nxt  = retry_r;
          pend_nxt = lbs_pkg::is_action(retry_r);
        end else if (cur_r == lbs_pkg::ST_SUSP && !host_r) begin
          cur_nxt  = lbs_pkg::ST_JOIN;
          pend_nxt = 1'b1;
        end else if (cur_r == lbs_pkg::ST_SUSP &&
                     lbs_pkg::time_due(item.now_ms, last_host_r + cfg.usb_silence_ms)) begin
          host_nxt = 1'b0;
          cur_nxt  = lbs_pkg::ST_JOIN;
          pend_nxt = 1'b1;
        end
        if (pend_nxt) begin
          pend_nxt = 1'b0;
          case (cur_nxt)
            lbs_pkg::ST_JOIN: cmd = lbs_pkg::CMD_JOIN;
            lbs_pkg::ST_ADDR: cmd = lbs_pkg::CMD_ADDR;
            lbs_pkg::ST_TIME: cmd = lbs_pkg::CMD_TIME;
            lbs_pkg::ST_CONN: begin
              if (!clkv_r) begin
                // no valid wall clock yet: fall back to time sync
                cur_nxt = lbs_pkg::ST_TIME;
                cmd     = lbs_pkg::CMD_TIME;
              end else begin
                cmd = lbs_pkg::CMD_TLS;
              end
            end
            default: cmd = lbs_pkg::CMD_NONE;
          endcase
        end
      end
      lbs_pkg::OP_INIT: begin
        retry_nxt     = lbs_pkg::ST_OFF;
        deadline_nxt  = '0;
        last_bo_nxt   = '0;
        host_nxt      = 1'b0;
        last_host_nxt = '0;
        base_nxt      = cfg.backoff_min_ms;
        prov_nxt      = item.event_flag;
        clkv_nxt      = item.time_valid_in && (item.wall_epoch > cfg.build_epoch);
        cur_nxt       = item.event_flag ? lbs_pkg::ST_JOIN : lbs_pkg::ST_OFF;
        pend_nxt      = item.event_flag;
      end
      lbs_pkg::OP_SET_PROV: begin
        prov_nxt = item.event_flag;
        if (!item.event_flag) begin
          close    = (cur_r != lbs_pkg::ST_OFF);
          host_nxt = 1'b0;
          cur_nxt  = lbs_pkg::ST_OFF;
          pend_nxt = 1'b0;
        end else if (cur_r == lbs_pkg::ST_OFF) begin
          cur_nxt  = host_r ? lbs_pkg::ST_SUSP : lbs_pkg::ST_JOIN;
          pend_nxt = !host_r;
        end
      end
      lbs_pkg::OP_JOIN: begin
        if (cur_r == lbs_pkg::ST_JOIN) begin
          if (item.event_flag) begin
            cur_nxt  = lbs_pkg::ST_ADDR;
            pend_nxt = 1'b1;
          end else begin
            retry_go  = 1'b1;
            retry_tgt = lbs_pkg::ST_JOIN;
          end
        end
      end
      lbs_pkg::OP_ADDR: begin
        if (cur_r == lbs_pkg::ST_ADDR) begin
          if (item.event_flag) begin
            cur_nxt  = clkv_r ? lbs_pkg::ST_CONN : lbs_pkg::ST_TIME;
            pend_nxt = 1'b1;
          end else begin
            retry_go  = 1'b1;
            retry_tgt = lbs_pkg::ST_ADDR;
          end
        end
      end
      lbs_pkg::OP_TIME: begin
        if (cur_r == lbs_pkg::ST_TIME) begin
          clkv_nxt = item.event_flag && (item.wall_epoch > cfg.build_epoch);
          if (clkv_nxt) begin
            cur_nxt  = lbs_pkg::ST_CONN;
            pend_nxt = 1'b1;
          end else begin
            retry_go  = 1'b1;
            retry_tgt = lbs_pkg::ST_TIME;
          end
        end
      end
      lbs_pkg::OP_TLS: begin
        if (cur_r == lbs_pkg::ST_CONN) begin
          if (item.event_flag) begin
            cur_nxt  = lbs_pkg::ST_LINK;
            pend_nxt = 1'b0;
            base_nxt = cfg.backoff_min_ms;
          end else begin
            retry_go  = 1'b1;
            retry_tgt = lbs_pkg::ST_CONN;
          end
        end
      end
      lbs_pkg::OP_AP_LOST: begin
        if (cur_r != lbs_pkg::ST_OFF && cur_r != lbs_pkg::ST_SUSP &&
            cur_r != lbs_pkg::ST_BACK) begin
          retry_go  = 1'b1;
          retry_tgt = lbs_pkg::ST_JOIN;
        end
      end
      lbs_pkg::OP_SRV_CLOSED: begin
        if (cur_r == lbs_pkg::ST_LINK || cur_r == lbs_pkg::ST_CONN) begin
          retry_go  = 1'b1;
          retry_tgt = lbs_pkg::ST_CONN;
        end
      end
      lbs_pkg::OP_HOST_FRAME: begin
        if (item.event_flag) begin
          last_host_nxt = item.now_ms;
          host_nxt      = 1'b1;
          if (cur_r != lbs_pkg::ST_OFF && cur_r != lbs_pkg::ST_SUSP) begin
            close    = 1'b1;
            cur_nxt  = lbs_pkg::ST_SUSP;
            pend_nxt = 1'b0;
          end
        end
      end
      lbs_pkg::OP_HOST_DISC: begin
        host_nxt = 1'b0;
        if (cur_r == lbs_pkg::ST_SUSP && prov_r) begin
          cur_nxt  = lbs_pkg::ST_JOIN;
          pend_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    // failure: close transport and wait out a jittered interval
    if (retry_go) begin
      close        = 1'b1;
      last_bo_nxt  = bo.interval;
      deadline_nxt = bo.deadline;
      retry_nxt    = retry_tgt;
      cur_nxt      = lbs_pkg::ST_BACK;
      pend_nxt     = 1'b0;
      base_nxt     = bo.base_nxt;
    end

    res.link_state   = cur_nxt;
    res.close_issued = close;
    res.start_cmd    = cmd;
    res.backoff_ms   = last_bo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= lbs_pkg::ST_OFF;
      retry_r     <= lbs_pkg::ST_OFF;
      pend_r      <= 1'b0;
      deadline_r  <= '0;
      base_r      <= lbs_pkg::BACKOFF_MIN_RST;
      last_bo_r   <= '0;
      clkv_r      <= 1'b0;
      prov_r      <= 1'b0;
      host_r      <= 1'b0;
      last_host_r <= '0;
    end else if (step) begin
      cur_r       <= cur_nxt;
      retry_r     <= retry_nxt;
      pend_r      <= pend_nxt;
      deadline_r  <= deadline_nxt;
      base_r      <= base_nxt;
      last_bo_r   <= last_bo_nxt;
      clkv_r      <= clkv_nxt;
      prov_r      <= prov_nxt;
      host_r      <= host_nxt;
      last_host_r <= last_host_nxt;
    end
  end

  a_pend_in_action_stage: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> lbs_pkg::is_action(cur_r))
    else $error("start pending outside a start-able stage");

  a_close_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.close_issued) |-> (res.link_state == lbs_pkg::ST_BACK ||
      res.link_state == lbs_pkg::ST_SUSP || res.link_state == lbs_pkg::ST_OFF))
    else $error("close issued without leaving the active stages");

  a_cmd_on_poll: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.start_cmd != lbs_pkg::CMD_NONE) |-> (item.opcode == lbs_pkg::OP_POLL))
    else $error("start command on a non-poll event");

endmodule

`default_nettype wire

/* hw/rtl/link_bringup_sequencer_backoff_core.sv */
// link bring-up sequencer with jittered doubling backoff
//
// in_if  : one event per transfer (opcode, now_ms, flags, wall_epoch, rand_byte)
// out_if : one result per event (link_state, close_issued, start_cmd, backoff_ms)
// cfg_if : register writes, index 0..3 (backoff min, backoff max, usb silence,
//          build epoch); ready whenever out of reset, only to be used while idle
//
// an accepted event waits in the input register until the result register
// can take a new value, then the sequencer state and the result register
// update together and the result is offered from the result register
// throughput is one event per cycle while out_if does not stall: the state
// update is a single pass of next-state logic plus the backoff datapath (8x30
// multiply, divide by 255 through a shift-add reciprocal, add or subtract, cap)
// when out_if stalls, the result register holds and the input register
// still takes one more event; in_if.ready drops only while both are full
// reset (rst_n low, synchronous) puts the link in off, clears the timers and
// restores the register defaults; in_if and cfg_if hold ready low meanwhile
// the init event re-clears the state but keeps the registers
`default_nettype none

module link_bringup_sequencer_backoff_core (
  input  wire logic clk,
  input  wire logic rst_n,
  lbs_in_if.sink    in_if,
  lbs_out_if.source out_if,
  lbs_cfg_if.sink   cfg_if
);

  // configuration registers
  lbs_pkg::cfg_t cfg_r;

  // input register
  logic           in_vld_r;
  lbs_pkg::item_t item_r;

  // result register
  logic          out_vld_r;
  lbs_pkg::res_t res_r;

  lbs_pkg::res_t res;
  logic          advance;
  logic          step;

  // no transfers are taken while in reset
  assign cfg_if.ready = rst_n;

  // the result register can take a new value when empty or being drained
  assign advance     = !out_vld_r || out_if.ready;
  assign step        = in_vld_r && advance;
  assign in_if.ready = rst_n && (!in_vld_r || advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.backoff_min_ms <= lbs_pkg::BACKOFF_MIN_RST;
      cfg_r.backoff_max_ms <= lbs_pkg::BACKOFF_MAX_RST;
      cfg_r.usb_silence_ms <= lbs_pkg::USB_SILENCE_RST;
      cfg_r.build_epoch    <= lbs_pkg::BUILD_EPOCH_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        lbs_pkg::REG_BACKOFF_MIN: cfg_r.backoff_min_ms <= cfg_if.data[31:0];
        lbs_pkg::REG_BACKOFF_MAX: cfg_r.backoff_max_ms <= cfg_if.data[31:0];
        lbs_pkg::REG_USB_SILENCE: cfg_r.usb_silence_ms <= cfg_if.data[31:0];
        lbs_pkg::REG_BUILD_EPOCH: cfg_r.build_epoch    <= cfg_if.data;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r.opcode        <= in_if.opcode;
      item_r.now_ms        <= in_if.now_ms;
      item_r.event_flag    <= in_if.event_flag;
      item_r.time_valid_in <= in_if.time_valid_in;
      item_r.wall_epoch    <= in_if.wall_epoch;
      item_r.rand_byte     <= in_if.rand_byte;
    end
  end

  // sequencer state and next-state logic
  lbs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.link_state   = res_r.link_state;
  assign out_if.close_issued = res_r.close_issued;
  assign out_if.start_cmd    = res_r.start_cmd;
  assign out_if.backoff_ms   = res_r.backoff_ms;

  // back-pressure only when both stages hold an undelivered event
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (in_vld_r && out_vld_r && !out_if.ready))
    else $error("input stalled while a stage is free");

  // every processed event shows up as a result in the next cycle
  a_step_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_vld_r)
    else $error("processed event produced no result");

endmodule

`default_nettype wire
